### hw/rtl/magnetometer_iron_calibration_unit_macros.svh
// Assertion shorthands for the calibration unit checker.
// Each macro expects clk and rst_n in scope.
`ifndef MAGNETOMETER_IRON_CALIBRATION_UNIT_MACROS_SVH
`define MAGNETOMETER_IRON_CALIBRATION_UNIT_MACROS_SVH

// Same-cycle implication.
`define MIC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mic checker: property failed");

// Next-cycle implication.
`define MIC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mic checker: property failed");

`endif

### hw/rtl/mic_pkg.sv
package mic_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SCALE_FRAC = 14;
    localparam int SCALE_W    = SCALE_FRAC + 4;
    localparam int COUNT_W    = 16;
    localparam int CFG_W      = 16;
    localparam int AXES       = 3;
    localparam int AXIS_W     = 2;

    // positive range max - min fits the sample width when read unsigned
    localparam int RANGE_W = SAMPLE_W;
    localparam int SUM_W   = RANGE_W + 2;
    // divisor is 6 * range, dividend is 2 * sum * 2^SCALE_FRAC + 3 * range
    localparam int DEN_W   = RANGE_W + 3;
    localparam int NUM_W   = SUM_W + SCALE_FRAC + 2;
    localparam int PROD_W  = SAMPLE_W + SCALE_W + 2;

    // APB
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_AXIS_SPAN    = 1'b1;
    localparam logic [CFG_W-1:0] SAMPLE_COUNT_RESET = CFG_W'(50);
    localparam logic [CFG_W-1:0] AXIS_SPAN_RESET    = CFG_W'(205);

    // command codes on the kind field
    localparam logic [2:0] KIND_DEFAULT = 3'd0;
    localparam logic [2:0] KIND_BEGIN   = 3'd1;
    localparam logic [2:0] KIND_ADD     = 3'd2;
    localparam logic [2:0] KIND_FINISH  = 3'd3;
    localparam logic [2:0] KIND_APPLY   = 3'd4;

    localparam logic [1:0] STATUS_OK     = 2'd0;
    localparam logic [1:0] STATUS_REJECT = 2'd1;
    localparam logic [1:0] STATUS_FEW    = 2'd2;
    localparam logic [1:0] STATUS_SPAN   = 2'd3;

    typedef struct packed {
        logic [2:0]                 kind;
        logic signed [SAMPLE_W-1:0] sample_x;
        logic signed [SAMPLE_W-1:0] sample_y;
        logic signed [SAMPLE_W-1:0] sample_z;
        logic                       sample_bad;
    } cmd_t;

    typedef struct packed {
        logic [1:0]                 status;
        logic signed [SAMPLE_W-1:0] out_x;
        logic signed [SAMPLE_W-1:0] out_y;
        logic signed [SAMPLE_W-1:0] out_z;
        logic [COUNT_W-1:0]         accepted_count;
        logic [COUNT_W-1:0]         rejected_count;
    } rsp_t;

    typedef enum logic [2:0] {
        OP_DEFAULT,
        OP_BEGIN,
        OP_ACCEPT,
        OP_REJECT,
        OP_FINISH,
        OP_APPLY,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t                             op;
        logic [AXES-1:0][SAMPLE_W-1:0]   sample;
    } job_t;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_HOLD
    } back_state_t;

endpackage

### hw/rtl/mic_front.sv
module mic_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_ready,
    input  mic_pkg::cmd_t   cmd,
    output logic            job_valid,
    input  logic            job_ready,
    output mic_pkg::job_t   job
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    mic_pkg::job_t        entry_reg [DEPTH];
    mic_pkg::job_t        job_in;
    logic [PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]       count_reg, count_next;
    logic                 push, pop;

    // decode the command into an operation for the back end
    always_comb
    begin
        job_in.sample = {cmd.sample_z, cmd.sample_y, cmd.sample_x};
        unique case (cmd.kind)
            mic_pkg::KIND_DEFAULT: job_in.op = mic_pkg::OP_DEFAULT;
            mic_pkg::KIND_BEGIN:   job_in.op = mic_pkg::OP_BEGIN;
            mic_pkg::KIND_ADD:     job_in.op = cmd.sample_bad ? mic_pkg::OP_REJECT
                                                              : mic_pkg::OP_ACCEPT;
            mic_pkg::KIND_FINISH:  job_in.op = mic_pkg::OP_FINISH;
            mic_pkg::KIND_APPLY:   job_in.op = mic_pkg::OP_APPLY;
            default:               job_in.op = mic_pkg::OP_NOP;
        endcase
    end

    assign cmd_ready = (count_reg != (PTR_W+1)'(DEPTH));
    assign job_valid = (count_reg != '0);
    assign job       = entry_reg[rd_ptr_reg];
    assign push      = cmd_valid && cmd_ready;
    assign pop       = job_valid && job_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= job_in;
        end
    end

endmodule

### hw/rtl/mic_div.sv
module mic_div (
    input  logic                clk,
    input  logic                rst_n,
    input  mic_pkg::div_req_t   req,
    output mic_pkg::div_rsp_t   rsp
);

    localparam int NUM_W = mic_pkg::NUM_W;
    localparam int DEN_W = mic_pkg::DEN_W;
    localparam int CNT_W = $clog2(NUM_W);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [DEN_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [DEN_W:0]      trial;

    // restoring division: dividend bits shift out the top of quo_reg while
    // quotient bits shift in at the bottom
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            rem_next  = '0;
            den_next  = req.den;
            quo_next  = req.num;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = quo_reg;

endmodule

### hw/rtl/mic_back.sv
module mic_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                job_valid,
    output logic                                job_ready,
    input  mic_pkg::job_t                       job,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output mic_pkg::rsp_t                       rsp,
    input  logic [mic_pkg::CFG_W-1:0]           min_sample_count,
    input  logic [mic_pkg::CFG_W-1:0]           min_axis_span,
    output mic_pkg::div_req_t                   div_req,
    input  mic_pkg::div_rsp_t                   div_rsp
);

    localparam int SAMPLE_W   = mic_pkg::SAMPLE_W;
    localparam int SCALE_W    = mic_pkg::SCALE_W;
    localparam int SCALE_FRAC = mic_pkg::SCALE_FRAC;
    localparam int COUNT_W    = mic_pkg::COUNT_W;
    localparam int AXES       = mic_pkg::AXES;
    localparam int AXIS_W     = mic_pkg::AXIS_W;
    localparam int RANGE_W    = mic_pkg::RANGE_W;
    localparam int SUM_W      = mic_pkg::SUM_W;
    localparam int DEN_W      = mic_pkg::DEN_W;
    localparam int NUM_W      = mic_pkg::NUM_W;
    localparam int PROD_W     = mic_pkg::PROD_W;

    localparam logic signed [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic [SCALE_W-1:0] SCALE_ONE = SCALE_W'(1) << SCALE_FRAC;
    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (SCALE_FRAC - 1);
    localparam logic signed [PROD_W-1:0] SAT_MAX = PROD_W'(SMP_MAX);
    localparam logic signed [PROD_W-1:0] SAT_MIN = {{(PROD_W-SAMPLE_W){1'b1}}, SMP_MIN};
    localparam logic [AXIS_W-1:0] LAST_AXIS = AXIS_W'(AXES - 1);

    typedef logic signed [SAMPLE_W-1:0] smp_t;
    typedef logic signed [PROD_W-1:0]   prod_t;

    mic_pkg::back_state_t   state_reg, state_next;
    logic [AXIS_W-1:0]      axis_reg, axis_next;
    smp_t                   min_reg  [AXES], min_next  [AXES];
    smp_t                   max_reg  [AXES], max_next  [AXES];
    smp_t                   bias_reg [AXES], bias_next [AXES];
    logic [SCALE_W-1:0]     scale_reg [AXES], scale_next [AXES];
    prod_t                  prod_reg [AXES], prod_next [AXES];
    logic [COUNT_W-1:0]     acc_reg, acc_next;
    logic [COUNT_W-1:0]     rej_reg, rej_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    mic_pkg::rsp_t          rsp_reg, rsp_next;

    logic                          out_free;
    logic                          take;
    smp_t                          smp [AXES];
    logic signed [SAMPLE_W:0]      rng [AXES];
    logic [RANGE_W-1:0]            rng_u [AXES];
    logic signed [SAMPLE_W:0]      mid2 [AXES];
    logic signed [SAMPLE_W:0]      diff [AXES];
    logic signed [SCALE_W:0]       scl_s [AXES];
    prod_t                         prod [AXES];
    prod_t                         rnd [AXES];
    prod_t                         shr [AXES];
    smp_t                          sat [AXES];
    logic signed [mic_pkg::CFG_W:0] span_s;
    logic                          span_bad;
    logic [SUM_W-1:0]              sum;
    logic [RANGE_W-1:0]            sel_rng;
    logic [DEN_W-1:0]              r3;
    logic [SCALE_W-1:0]            quo_sat;

    assign out_free  = !rsp_valid_reg || rsp_ready;
    assign job_ready = (state_reg == mic_pkg::ST_IDLE) && out_free;
    assign take      = job_valid && job_ready;
    assign span_s    = $signed({1'b0, min_axis_span});

    // per-axis datapath: ranges, midpoints, span check, apply products, rounding and saturation
    always_comb
    begin
        span_bad = 1'b0;
        for (int a = 0; a < AXES; a++)
        begin
            smp[a]   = $signed(job.sample[a]);
            rng[a]   = {max_reg[a][SAMPLE_W-1], max_reg[a]}
                     - {min_reg[a][SAMPLE_W-1], min_reg[a]};
            rng_u[a] = rng[a][RANGE_W-1:0];
            mid2[a]  = {min_reg[a][SAMPLE_W-1], min_reg[a]}
                     + {max_reg[a][SAMPLE_W-1], max_reg[a]};
            if (rng[a] <= 0 || rng[a] < span_s)
            begin
                span_bad = 1'b1;
            end
            diff[a]  = {smp[a][SAMPLE_W-1], smp[a]}
                     - {bias_reg[a][SAMPLE_W-1], bias_reg[a]};
            scl_s[a] = $signed({1'b0, scale_reg[a]});
            prod[a]  = PROD_W'(diff[a]) * PROD_W'(scl_s[a]);
            rnd[a]   = prod_reg[a] + ROUND_HALF;
            shr[a]   = rnd[a] >>> SCALE_FRAC;
            if (shr[a] > SAT_MAX)
            begin
                sat[a] = SMP_MAX;
            end
            else if (shr[a] < SAT_MIN)
            begin
                sat[a] = SMP_MIN;
            end
            else
            begin
                sat[a] = shr[a][SAMPLE_W-1:0];
            end
        end
        sum = SUM_W'(rng_u[0]) + SUM_W'(rng_u[1]) + SUM_W'(rng_u[2]);
    end

    // divider operands for the axis in progress, and the saturated quotient
    always_comb
    begin
        sel_rng = rng_u[axis_reg];
        r3      = DEN_W'(sel_rng) + (DEN_W'(sel_rng) << 1);
        quo_sat = (div_rsp.quo > NUM_W'(SCALE_MAX)) ? SCALE_MAX
                                                    : div_rsp.quo[SCALE_W-1:0];
    end

    always_comb
    begin
        state_next     = state_reg;
        axis_next      = axis_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        bias_next      = bias_reg;
        scale_next     = scale_reg;
        prod_next      = prod_reg;
        acc_next       = acc_reg;
        rej_next       = rej_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        rsp_next       = rsp_reg;
        div_req.start  = 1'b0;
        div_req.num    = (NUM_W'(sum) << (SCALE_FRAC + 1)) + NUM_W'(r3);
        div_req.den    = r3 << 1;

        unique case (state_reg)
            mic_pkg::ST_IDLE:
            begin
                if (take)
                begin
                    rsp_next = '0;
                    unique case (job.op)
                        mic_pkg::OP_DEFAULT:
                        begin
                            for (int a = 0; a < AXES; a++)
                            begin
                                bias_next[a]  = '0;
                                scale_next[a] = SCALE_ONE;
                            end
                        end
                        mic_pkg::OP_BEGIN:
                        begin
                            for (int a = 0; a < AXES; a++)
                            begin
                                min_next[a] = SMP_MAX;
                                max_next[a] = SMP_MIN;
                            end
                            acc_next = '0;
                            rej_next = '0;
                        end
                        mic_pkg::OP_ACCEPT:
                        begin
                            for (int a = 0; a < AXES; a++)
                            begin
                                if (smp[a] < min_reg[a])
                                begin
                                    min_next[a] = smp[a];
                                end
                                if (smp[a] > max_reg[a])
                                begin
                                    max_next[a] = smp[a];
                                end
                            end
                            if (acc_reg != '1)
                            begin
                                acc_next = acc_reg + 1'b1;
                            end
                        end
                        mic_pkg::OP_REJECT:
                        begin
                            if (rej_reg != '1)
                            begin
                                rej_next = rej_reg + 1'b1;
                            end
                            rsp_next.status = mic_pkg::STATUS_REJECT;
                        end
                        mic_pkg::OP_FINISH:
                        begin
                            if (acc_reg < min_sample_count)
                            begin
                                rsp_next.status = mic_pkg::STATUS_FEW;
                            end
                            else if (span_bad)
                            begin
                                rsp_next.status = mic_pkg::STATUS_SPAN;
                            end
                            else
                            begin
                                for (int a = 0; a < AXES; a++)
                                begin
                                    bias_next[a] = mid2[a][SAMPLE_W:1];
                                end
                                axis_next  = '0;
                                state_next = mic_pkg::ST_DIV_START;
                            end
                        end
                        mic_pkg::OP_APPLY:
                        begin
                            prod_next  = prod;
                            state_next = mic_pkg::ST_MUL;
                        end
                        default:
                        begin
                        end
                    endcase
                    rsp_next.accepted_count = acc_next;
                    rsp_next.rejected_count = rej_next;
                    rsp_valid_next = (state_next == mic_pkg::ST_IDLE);
                end
            end
            mic_pkg::ST_MUL:
            begin
                if (out_free)
                begin
                    rsp_next                = '0;
                    rsp_next.out_x          = sat[0];
                    rsp_next.out_y          = sat[1];
                    rsp_next.out_z          = sat[2];
                    rsp_next.accepted_count = acc_reg;
                    rsp_next.rejected_count = rej_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = mic_pkg::ST_IDLE;
                end
            end
            mic_pkg::ST_DIV_START:
            begin
                div_req.start = 1'b1;
                state_next    = mic_pkg::ST_DIV_WAIT;
            end
            mic_pkg::ST_DIV_WAIT:
            begin
                if (div_rsp.done)
                begin
                    scale_next[axis_reg] = quo_sat;
                    if (axis_reg == LAST_AXIS)
                    begin
                        state_next = mic_pkg::ST_HOLD;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 1'b1;
                        state_next = mic_pkg::ST_DIV_START;
                    end
                end
            end
            mic_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    rsp_next                = '0;
                    rsp_next.accepted_count = acc_reg;
                    rsp_next.rejected_count = rej_reg;
                    rsp_valid_next          = 1'b1;
                    state_next              = mic_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mic_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mic_pkg::ST_IDLE;
            axis_reg      <= '0;
            acc_reg       <= '0;
            rej_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int a = 0; a < AXES; a++)
            begin
                min_reg[a]   <= SMP_MAX;
                max_reg[a]   <= SMP_MIN;
                bias_reg[a]  <= '0;
                scale_reg[a] <= SCALE_ONE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            axis_reg      <= axis_next;
            acc_reg       <= acc_next;
            rej_reg       <= rej_next;
            rsp_valid_reg <= rsp_valid_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            bias_reg      <= bias_next;
            scale_reg     <= scale_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        rsp_reg  <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

### hw/rtl/magnetometer_iron_calibration_unit.sv
// Hard/soft-iron magnetometer calibration, min/max tracking, diagonal scale.
// Command channel (cmd_valid/cmd_ready/cmd): one command beat carries kind and
// a three-axis Q5.11 sample. Result channel (rsp_valid/rsp_ready/rsp): exactly
// one result beat per command, in command order.
// A two-entry queue sits between the command decoder and the executor, and the
// result sits in an output register, so a stalled receiver backs up only as
// far as that queue; cmd_ready drops once it is full.
// Apply does one registered 17x19 multiply per axis before its result. The
// executor takes one beat per cycle for default/begin/add while the result
// register is free; an apply holds off the next command until its result is
// out. A successful finish runs the one-bit-per-cycle divider once per axis,
// 34 steps each, before its result; a failed finish answers like an add.
// Reset: bias 0, scale 1.0, trackers at their extremes, counters zero,
// min_sample_count 50, min_axis_span 205, both channels empty.
// Configuration (APB, pready tied high) is to be written by the user only while
// no command is in flight; the block itself does not enforce this.
module magnetometer_iron_calibration_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    output logic                                cmd_ready,
    input  mic_pkg::cmd_t                       cmd,
    output logic                                rsp_valid,
    input  logic                                rsp_ready,
    output mic_pkg::rsp_t                       rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mic_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mic_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [mic_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int CFG_W      = mic_pkg::CFG_W;
    localparam int APB_DATA_W = mic_pkg::APB_DATA_W;

    logic [CFG_W-1:0]      count_cfg_reg, count_cfg_next;
    logic [CFG_W-1:0]      span_cfg_reg, span_cfg_next;
    logic                  cfg_wr;
    logic                  job_valid;
    logic                  job_ready;
    mic_pkg::job_t         job;
    mic_pkg::div_req_t     div_req;
    mic_pkg::div_rsp_t     div_rsp;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        count_cfg_next = count_cfg_reg;
        span_cfg_next  = span_cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[2])
                mic_pkg::REG_SAMPLE_COUNT: count_cfg_next = pwdata[CFG_W-1:0];
                mic_pkg::REG_AXIS_SPAN:    span_cfg_next  = pwdata[CFG_W-1:0];
                default:                   ;
            endcase
        end
        unique case (paddr[2])
            mic_pkg::REG_SAMPLE_COUNT: prdata = APB_DATA_W'(count_cfg_reg);
            mic_pkg::REG_AXIS_SPAN:    prdata = APB_DATA_W'(span_cfg_reg);
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_cfg_reg <= mic_pkg::SAMPLE_COUNT_RESET;
            span_cfg_reg  <= mic_pkg::AXIS_SPAN_RESET;
        end
        else
        begin
            count_cfg_reg <= count_cfg_next;
            span_cfg_reg  <= span_cfg_next;
        end
    end

    mic_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job)
    );

    mic_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .job_valid        (job_valid),
        .job_ready        (job_ready),
        .job              (job),
        .rsp_valid        (rsp_valid),
        .rsp_ready        (rsp_ready),
        .rsp              (rsp),
        .min_sample_count (count_cfg_reg),
        .min_axis_span    (span_cfg_reg),
        .div_req          (div_req),
        .div_rsp          (div_rsp)
    );

    mic_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

endmodule

### hw/rtl/mic_checker.sv
`include "magnetometer_iron_calibration_unit_macros.svh"

module mic_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cmd_valid,
    input  logic                                cmd_ready,
    input  mic_pkg::cmd_t                       cmd,
    input  logic                                rsp_valid,
    input  logic                                rsp_ready,
    input  mic_pkg::rsp_t                       rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [mic_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [mic_pkg::APB_DATA_W-1:0]      pwdata,
    input  logic [mic_pkg::APB_DATA_W-1:0]      prdata,
    input  logic                                pready
);

    logic                           rsp_fail;
    logic                           rsp_zero;
    logic                           count_wr;
    logic [mic_pkg::CFG_W-1:0]      count_rd;
    logic [mic_pkg::CFG_W-1:0]      count_wdata;

    assign rsp_fail    = rsp_valid && (rsp.status != mic_pkg::STATUS_OK);
    assign rsp_zero    = (rsp.out_x == 0) && (rsp.out_y == 0) && (rsp.out_z == 0);
    assign count_wr    = psel && penable && pwrite && !paddr[2];
    assign count_rd    = prdata[mic_pkg::CFG_W-1:0];
    assign count_wdata = pwdata[mic_pkg::CFG_W-1:0];

    // a waiting command beat holds
    `MIC_ASSERT_NXT(a_cmd_hold, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd))

    // a stalled result beat holds
    `MIC_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

    // only apply fills the sample fields, and apply always reports ok
    `MIC_ASSERT_IMP(a_fail_zero, rsp_fail, rsp_zero)

    // a write to the sample count register reads back on the next cycle
    `MIC_ASSERT_NXT(a_cfg_readback, count_wr, paddr[2] || count_rd == $past(count_wdata))

    // register reads never show bits above the register width
    `MIC_ASSERT_IMP(a_prdata_upper, pready, prdata[mic_pkg::APB_DATA_W-1:mic_pkg::CFG_W] == 0)

endmodule

bind magnetometer_iron_calibration_unit mic_checker u_mic_checker (.*);
